// ===== rtl/scan_breakpoint_segmenter_top_assert.svh =====
// Assertion macros used by the scan breakpoint segmenter checker.
`ifndef SCAN_BREAKPOINT_SEGMENTER_TOP_ASSERT_SVH
`define SCAN_BREAKPOINT_SEGMENTER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define SBS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scan segmenter check failed (same cycle)");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define SBS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scan segmenter check failed (next cycle)");

`endif

// ===== rtl/sbs_pkg.sv =====
// Types, constants and helpers of the scan breakpoint segmenter.
package sbs_pkg;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ANGLE,
    ST_GAIN,
    ST_ROT,
    ST_ROUND,
    ST_SQX,
    ST_SQY,
    ST_SQJ,
    ST_UPDATE
  } sbs_state_e;

  // Register indexes (paddr[3:2])
  localparam logic [1:0] REG_START_ANGLE = 2'd0;
  localparam logic [1:0] REG_ANGLE_STEP  = 2'd1;
  localparam logic [1:0] REG_JOIN_DIST   = 2'd2;

  localparam logic [15:0] START_ANGLE_RST = 16'hC000;
  localparam logic [11:0] ANGLE_STEP_RST  = 12'd46;
  localparam logic [15:0] JOIN_DIST_RST   = 16'd52;

  // Field widths and result packing, lowest bit first
  localparam int RANGE_W    = 16;
  localparam int IDX_W      = 12;
  localparam int SEGNUM_W   = 12;
  localparam int COORD_W    = 17;
  localparam int COUNT_W    = 13;
  localparam int OFS_FX     = SEGNUM_W;
  localparam int OFS_FY     = OFS_FX + COORD_W;
  localparam int OFS_LX     = OFS_FY + COORD_W;
  localparam int OFS_LY     = OFS_LX + COORD_W;
  localparam int OFS_CNT    = OFS_LY + COORD_W;
  localparam int OUT_BITS   = OFS_CNT + COUNT_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  // CORDIC datapath
  localparam int XY_W    = 35;  // x, y in Q16 mm with headroom for gain growth
  localparam int Z_W     = 34;  // residual angle, 2^-32 turn
  localparam int STEP_W  = 5;
  localparam int ATAN_N  = 24;
  localparam logic [29:0] GAIN_Q30 = 30'd652032874;  // 1/1.6468 in Q30
  localparam logic signed [19:0] COORD_MAX = 20'sd65535;

  // atan(2^-i) in 2^-32 turn
  localparam logic [29:0] ATAN_TURN32 [ATAN_N] = '{
    30'h20000000, 30'h12E4051E, 30'h09FB385B, 30'h051111D4, 30'h028B0D43, 30'h0145D7E1,
    30'h00A2F61E, 30'h00517C55, 30'h0028BE53, 30'h00145F2F, 30'h000A2F98, 30'h000517CC,
    30'h00028BE6, 30'h000145F3, 30'h0000A2FA, 30'h0000517D, 30'h000028BE, 30'h0000145F,
    30'h00000A30, 30'h00000518, 30'h0000028C, 30'h00000146, 30'h000000A3, 30'h00000051
  };

  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [19:0] v);
    logic signed [COORD_W-1:0] r;
    if (v > COORD_MAX) begin
      r = COORD_W'(COORD_MAX);
    end else if (v < -COORD_MAX) begin
      r = COORD_W'(-COORD_MAX);
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/scan_breakpoint_segmenter_top.sv =====
// Laser scan breakpoint segmenter: polar samples to xy, gap test, segment results.
//
// Channel  | Dir | Handshake               | Payload
// ---------+-----+-------------------------+-------------------------------------------
// s_axis   | in  | tvalid/tready           | tdata=range_mm, tuser=range_valid,
//          |     |                         | tlast=scan_last
// m_axis   | out | tvalid/tready           | tdata=segment fields, tlast=segment_scan_end
// apb      | in  | psel/penable/pwrite     | 0x0 start_angle, 0x4 angle_step,
//          |     | (pready tied high)      | 0x8 join_distance_mm
//
// A valid sample occupies the block from accept to accept: angle multiply,
// gain multiply, one CORDIC step per cycle on the shared shift/add unit,
// rounding, three squares on the shared multiplier and the segment update.
// The first valid point of a scan skips the squares. An invalid sample goes
// straight from accept to the segment update.
// The update waits while a previous result still sits unread in the output
// register. Reset is asynchronous, active low; no clearing pass is needed.
module scan_breakpoint_segmenter_top #(
  parameter int MAX_SAMPLES  = 4096,
  parameter int RANGE_BITS   = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // sample stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [sbs_pkg::RANGE_W-1:0]    s_axis_tdata,   // [15:0] range_mm
  input  logic                           s_axis_tuser,   // [0] range_valid
  input  logic                           s_axis_tlast,   // scan_last
  // segment stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [11:0] segment_number, [28:12] first_x_mm, [45:29] first_y_mm,
  // [62:46] last_x_mm, [79:63] last_y_mm, [92:80] point_count, [95:93] zero
  output logic [sbs_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic                           m_axis_tlast,   // segment_scan_end
  // configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [3:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import sbs_pkg::*;

  localparam int STEPS = (CORDIC_STEPS > ATAN_N) ? ATAN_N : CORDIC_STEPS;
  localparam longint RMAX = (64'd1 << RANGE_BITS) - 64'd1;
  localparam int CAP_INT = (MAX_SAMPLES < 8191) ? MAX_SAMPLES : 8191;
  localparam logic [COUNT_W-1:0] SEG_CAP = COUNT_W'(CAP_INT);

  // ---------------------------------------------------------------- config
  logic [15:0] start_angle_q;
  logic [11:0] angle_step_q;
  logic [15:0] join_dist_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    unique case (paddr[3:2])
      REG_START_ANGLE: prdata = {16'b0, start_angle_q};
      REG_ANGLE_STEP:  prdata = {20'b0, angle_step_q};
      REG_JOIN_DIST:   prdata = {16'b0, join_dist_q};
      default:         prdata = 32'b0;
    endcase
  end

  // ---------------------------------------------------------------- state
  sbs_state_e state_q, state_d;
  logic [STEP_W-1:0] step_q;

  logic [IDX_W-1:0]          idx_q;
  logic                      have_prev_q;
  logic signed [COORD_W-1:0] prev_x_q, prev_y_q, first_x_q, first_y_q;
  logic [COUNT_W-1:0]        count_q;
  logic [SEGNUM_W-1:0]       serial_q;

  // latched sample and datapath
  logic [RANGE_W-1:0]        r_q;
  logic                      r_valid_q, r_last_q;
  logic [15:0]               ang_q;
  logic signed [XY_W-1:0]    x_q, y_q;
  logic signed [Z_W-1:0]     z_q;
  logic signed [COORD_W-1:0] px_q, py_q;
  logic [35:0]               acc_q;
  logic [31:0]               jsq_q;

  // output register
  logic                  m_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;
  logic                  out_last_q;

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  // ---------------------------------------------------------------- control
  logic in_acc, upd_go, last_step;

  assign in_acc    = s_axis_tvalid & s_axis_tready;
  assign last_step = (step_q == STEP_W'(STEPS - 1));

  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);
    upd_go        = (state_q == ST_UPDATE) && (!m_valid_q || m_axis_tready);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_acc) state_d = s_axis_tuser ? ST_ANGLE : ST_UPDATE;
      ST_ANGLE:  state_d = ST_GAIN;
      ST_GAIN:   state_d = ST_ROT;
      ST_ROT:    if (last_step) state_d = ST_ROUND;
      ST_ROUND:  state_d = have_prev_q ? ST_SQX : ST_UPDATE;
      ST_SQX:    state_d = ST_SQY;
      ST_SQY:    state_d = ST_SQJ;
      ST_SQJ:    state_d = ST_UPDATE;
      ST_UPDATE: if (upd_go) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- shared multiplier
  logic signed [17:0] dx, dy, mul_a;
  logic signed [30:0] mul_b;
  logic signed [48:0] prod;

  assign dx = {px_q[COORD_W-1], px_q} - {prev_x_q[COORD_W-1], prev_x_q};
  assign dy = {py_q[COORD_W-1], py_q} - {prev_y_q[COORD_W-1], prev_y_q};

  always_comb begin
    case (state_q)
      ST_ANGLE: begin
        mul_a = 18'({6'b0, idx_q});
        mul_b = 31'({19'b0, angle_step_q});
      end
      ST_GAIN: begin
        mul_a = 18'({2'b0, r_q});
        mul_b = 31'({1'b0, GAIN_Q30});
      end
      ST_SQX: begin
        mul_a = dx;
        mul_b = 31'(dx);
      end
      ST_SQY: begin
        mul_a = dy;
        mul_b = 31'(dy);
      end
      ST_SQJ: begin
        mul_a = 18'({2'b0, join_dist_q});
        mul_b = 31'({15'b0, join_dist_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // ---------------------------------------------------------------- CORDIC step unit
  logic signed [XY_W-1:0] sh_x, sh_y;
  logic signed [Z_W-1:0]  atan_z;

  assign sh_x   = y_q >>> step_q;
  assign sh_y   = x_q >>> step_q;
  assign atan_z = Z_W'({1'b0, ATAN_TURN32[step_q]});

  // rounding and quadrant fold; the shift keeps the sign of small negative results
  logic signed [XY_W-1:0] x_rnd, y_rnd;
  logic signed [19:0]     xr, yr, tx, ty;

  assign x_rnd = x_q + XY_W'(32768);
  assign y_rnd = y_q + XY_W'(32768);
  assign xr    = 20'(x_rnd >>> 16);
  assign yr    = 20'(y_rnd >>> 16);

  always_comb begin
    case (ang_q[15:14])
      2'd1:    begin tx = -yr; ty = xr;  end
      2'd2:    begin tx = -xr; ty = -yr; end
      2'd3:    begin tx = yr;  ty = -xr; end
      default: begin tx = xr;  ty = yr;  end
    endcase
  end

  // range clamp to the configured width
  logic [RANGE_W-1:0] r_in;
  assign r_in = (64'(s_axis_tdata) > RMAX) ? RANGE_W'(RMAX) : s_axis_tdata;

  // ---------------------------------------------------------------- segment update
  logic                      joined, brk, emit, prev_upd, new_seg;
  logic [COUNT_W-1:0]        cnt_after;
  logic signed [COORD_W-1:0] first_x_n, first_y_n, prev_x_n, prev_y_n;
  logic [IDX_W:0]            idx_inc;
  logic [IDX_W-1:0]          idx_wrap;
  logic [OUT_BITS-1:0]       out_pack;

  always_comb begin
    joined   = acc_q < {4'b0, jsq_q};
    brk      = r_valid_q && have_prev_q && !joined;
    new_seg  = r_valid_q && (!have_prev_q || brk);
    emit     = brk || r_last_q;
    prev_upd = r_valid_q && !(brk && r_last_q);

    if (!r_valid_q) begin
      cnt_after = count_q;
    end else if (new_seg) begin
      cnt_after = COUNT_W'(1);
    end else if (count_q < SEG_CAP) begin
      cnt_after = count_q + COUNT_W'(1);
    end else begin
      cnt_after = count_q;
    end

    first_x_n = new_seg  ? px_q : first_x_q;
    first_y_n = new_seg  ? py_q : first_y_q;
    prev_x_n  = prev_upd ? px_q : prev_x_q;
    prev_y_n  = prev_upd ? py_q : prev_y_q;

    idx_inc  = {1'b0, idx_q} + (IDX_W + 1)'(1);
    idx_wrap = (32'(idx_inc) >= 32'(MAX_SAMPLES)) ? '0 : idx_inc[IDX_W-1:0];

    // break closes the old segment; else the scan end closes the open or an empty one
    if (brk) begin
      out_pack = {count_q, prev_y_q, prev_x_q, first_y_q, first_x_q, serial_q};
    end else if (cnt_after == '0) begin
      out_pack = {{(OUT_BITS - SEGNUM_W){1'b0}}, serial_q};
    end else begin
      out_pack = {cnt_after, prev_y_n, prev_x_n, first_y_n, first_x_n, serial_q};
    end
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      step_q        <= '0;
      start_angle_q <= START_ANGLE_RST;
      angle_step_q  <= ANGLE_STEP_RST;
      join_dist_q   <= JOIN_DIST_RST;
      idx_q         <= '0;
      have_prev_q   <= 1'b0;
      prev_x_q      <= '0;
      prev_y_q      <= '0;
      first_x_q     <= '0;
      first_y_q     <= '0;
      count_q       <= '0;
      serial_q      <= '0;
      m_valid_q     <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_wr) begin
        unique case (paddr[3:2])
          REG_START_ANGLE: start_angle_q <= pwdata[15:0];
          REG_ANGLE_STEP:  angle_step_q  <= pwdata[11:0];
          REG_JOIN_DIST:   join_dist_q   <= pwdata[15:0];
          default: ;
        endcase
      end

      if (state_q == ST_GAIN) begin
        step_q <= '0;
      end else if (state_q == ST_ROT) begin
        step_q <= step_q + STEP_W'(1);
      end

      if (upd_go) begin
        prev_x_q  <= prev_x_n;
        prev_y_q  <= prev_y_n;
        first_x_q <= first_x_n;
        first_y_q <= first_y_n;
        if (r_last_q) begin
          idx_q       <= '0;
          have_prev_q <= 1'b0;
          count_q     <= '0;
          serial_q    <= '0;
        end else begin
          idx_q       <= idx_wrap;
          have_prev_q <= have_prev_q | r_valid_q;
          count_q     <= cnt_after;
          serial_q    <= brk ? serial_q + SEGNUM_W'(1) : serial_q;
        end
      end

      if (upd_go && emit) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      r_q       <= r_in;
      r_valid_q <= s_axis_tuser;
      r_last_q  <= s_axis_tlast;
    end

    case (state_q)
      ST_ANGLE: ang_q <= start_angle_q + prod[15:0];
      ST_GAIN: begin
        x_q <= XY_W'({1'b0, prod[45:14]});
        y_q <= '0;
        z_q <= Z_W'({ang_q[13:0], 16'b0});
      end
      ST_ROT: begin
        if (!z_q[Z_W-1]) begin
          x_q <= x_q - sh_x;
          y_q <= y_q + sh_y;
          z_q <= z_q - atan_z;
        end else begin
          x_q <= x_q + sh_x;
          y_q <= y_q - sh_y;
          z_q <= z_q + atan_z;
        end
      end
      ST_ROUND: begin
        px_q <= sat_coord(tx);
        py_q <= sat_coord(ty);
      end
      ST_SQX: acc_q <= 36'(prod[34:0]);
      ST_SQY: acc_q <= acc_q + 36'(prod[34:0]);
      ST_SQJ: jsq_q <= prod[31:0];
      default: ;
    endcase

    if (upd_go && emit) begin
      out_data_q <= OUT_DATA_W'(out_pack);
      out_last_q <= r_last_q;
    end
  end

endmodule

// ===== rtl/sbs_checker.sv =====
// Port-level checks of the scan breakpoint segmenter, bound to the top level.
`include "scan_breakpoint_segmenter_top_assert.svh"

module sbs_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [sbs_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic                           m_axis_tlast
);
  import sbs_pkg::*;

  logic in_xact, out_stall, empty_seg;

  assign in_xact   = s_axis_tvalid && s_axis_tready;
  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign empty_seg = m_axis_tvalid && (m_axis_tdata[OFS_CNT +: COUNT_W] == '0);

  // a stalled result holds
  `SBS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
  // one sample in flight: busy right after each input transaction
  `SBS_ASSERT_NEXT(a_busy_after_in, clk_i, rst_ni, in_xact, !s_axis_tready)
  // an empty segment only closes a scan, with serial and points all zero
  `SBS_ASSERT_NOW(a_empty_seg, clk_i, rst_ni, empty_seg, m_axis_tlast && (m_axis_tdata[OFS_CNT-1:0] == '0))

endmodule

bind scan_breakpoint_segmenter_top sbs_checker u_sbs_checker (.*);

// ===== dv/tb_scan_breakpoint_segmenter_top.sv =====
// Self-checking testbench for the laser scan breakpoint segmenter.
module tb_scan_breakpoint_segmenter_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sbs_pkg::*;

  localparam int    MAX_SAMPLES   = 4096;
  localparam int    RANGE_BITS    = 16;
  localparam int    CORDIC_STEPS  = 16;
  localparam int    CORDIC_ITERS  = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
  localparam int    COUNT_CAP     = (MAX_SAMPLES < 8191) ? MAX_SAMPLES : 8191;
  localparam longint GAIN_Q30     = 652032874;
  localparam longint MM_LIMIT     = 65535;
  localparam int    SETTLE_CYCLES = 64;        // well past the time one sample spends in the block
  localparam longint CYCLE_LIMIT  = 3000000;

  // atan(2^-i) in 2^-32 turn
  localparam longint ATAN_STEP [24] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct {
    logic [11:0]        number;
    logic signed [16:0] first_x;
    logic signed [16:0] first_y;
    logic signed [16:0] last_x;
    logic signed [16:0] last_y;
    logic [12:0]        count;
    logic               scan_end;
  } segment_t;

  // Receiver stall patterns
  typedef enum int {RX_STREAM, RX_SPARSE, RX_PERIODIC, RX_COIN} rx_mode_e;

  // Tracks scan state, predicts closed segments and checks them in order.
  class segment_tracker;
    logic [15:0]        start_angle;
    logic [11:0]        angle_step;
    logic [15:0]        join_mm;
    int                 sample_idx;
    logic               have_prev;
    logic signed [16:0] prev_x, prev_y, first_x, first_y;
    logic [12:0]        seg_count;
    logic [11:0]        seg_serial;
    segment_t           awaited[$];
    int unsigned        faults;

    function new();
      start_angle = 16'hC000;
      angle_step  = 12'd46;
      join_mm     = 16'd52;
      sample_idx  = 0;
      have_prev   = 1'b0;
      prev_x = '0; prev_y = '0; first_x = '0; first_y = '0;
      seg_count   = '0;
      seg_serial  = '0;
      faults      = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        REG_START_ANGLE: start_angle = val[15:0];
        REG_ANGLE_STEP:  angle_step  = val[11:0];
        REG_JOIN_DIST:   join_mm     = val[15:0];
        default: ;
      endcase
    endfunction

    function logic signed [16:0] clamp_mm(longint v);
      if (v > MM_LIMIT) return 17'(MM_LIMIT);
      if (v < -MM_LIMIT) return 17'(-MM_LIMIT);
      return v[16:0];
    endfunction

    // Polar to cartesian: gain-compensated CORDIC on the first quadrant,
    // then an exact quarter-turn rotation by the top two angle bits.
    function void beam_to_xy(input logic [15:0] r, input logic [15:0] ang,
                             output logic signed [16:0] px, output logic signed [16:0] py);
      longint x, y, z, dx, dy, xr, yr, tx, ty;
      x = (longint'(r) * GAIN_Q30) >>> 14;
      y = 0;
      z = longint'(ang[13:0]) << 16;
      for (int i = 0; i < CORDIC_ITERS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= ATAN_STEP[i];
        end else begin
          x += dx; y -= dy; z += ATAN_STEP[i];
        end
      end
      xr = (x + 32768) >>> 16;
      yr = (y + 32768) >>> 16;
      case (ang[15:14])
        2'd1:    begin tx = -yr; ty = xr;  end
        2'd2:    begin tx = -xr; ty = -yr; end
        2'd3:    begin tx = yr;  ty = -xr; end
        default: begin tx = xr;  ty = yr;  end
      endcase
      px = clamp_mm(tx);
      py = clamp_mm(ty);
    endfunction

    function void record_segment(logic signed [16:0] fx, logic signed [16:0] fy,
                                 logic signed [16:0] lx, logic signed [16:0] ly,
                                 logic [12:0] cnt, logic at_end);
      segment_t s;
      s.number = seg_serial;
      s.first_x = fx; s.first_y = fy;
      s.last_x = lx;  s.last_y = ly;
      s.count = cnt;
      s.scan_end = at_end;
      awaited.insert(awaited.size(), s);
    endfunction

    // One accepted sample transaction.
    function void take_sample(logic [15:0] r, logic valid, logic last);
      logic [15:0]        ang;
      logic signed [16:0] px, py;
      longint             ddx, ddy, d2, j2;
      bit                 closed;
      ang = start_angle + 16'(sample_idx) * 16'(angle_step);
      closed = 1'b0;
      if (valid) begin
        beam_to_xy(r, ang, px, py);
        if (!have_prev) begin
          first_x = px; first_y = py; seg_count = 13'd1;
        end else begin
          ddx = longint'(px) - longint'(prev_x);
          ddy = longint'(py) - longint'(prev_y);
          d2 = ddx * ddx + ddy * ddy;
          j2 = longint'(join_mm) * longint'(join_mm);
          if (d2 < j2) begin
            if (seg_count < COUNT_CAP) seg_count++;
          end else begin
            record_segment(first_x, first_y, prev_x, prev_y, seg_count, last);
            closed = 1'b1;
            seg_serial++;
            first_x = px; first_y = py; seg_count = 13'd1;
          end
        end
        // a point that breaks the run on the final sample is dropped
        if (!closed || !last) begin
          prev_x = px; prev_y = py;
        end
        have_prev = 1'b1;
      end
      if (last) begin
        if (!closed) begin
          if (seg_count == 0) record_segment('0, '0, '0, '0, '0, 1'b1);
          else record_segment(first_x, first_y, prev_x, prev_y, seg_count, 1'b1);
        end
        sample_idx = 0; have_prev = 1'b0; seg_count = '0; seg_serial = '0;
      end else begin
        sample_idx = (sample_idx + 1 >= MAX_SAMPLES) ? 0 : ((sample_idx + 1) & 12'hFFF);
      end
    endfunction

    function void compare(string field, longint want, longint got);
      if (want != got) begin
        faults++;
        $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
      end
    endfunction

    // One accepted segment transaction.
    function void match_segment(logic [OUT_DATA_W-1:0] data, logic at_end);
      segment_t want;
      if (awaited.size() == 0) begin
        faults++;
        $display("%0t: segment expected none, got number %0d count %0d", $time,
                 data[SEGNUM_W-1:0], data[OFS_CNT +: COUNT_W]);
        return;
      end
      want = awaited.pop_front();
      compare("segment_number", want.number, data[SEGNUM_W-1:0]);
      compare("first_x_mm", want.first_x, $signed(data[OFS_FX +: COORD_W]));
      compare("first_y_mm", want.first_y, $signed(data[OFS_FY +: COORD_W]));
      compare("last_x_mm", want.last_x, $signed(data[OFS_LX +: COORD_W]));
      compare("last_y_mm", want.last_y, $signed(data[OFS_LY +: COORD_W]));
      compare("point_count", want.count, data[OFS_CNT +: COUNT_W]);
      compare("segment_scan_end", want.scan_end, at_end);
      compare("tdata padding", 0, data[OUT_DATA_W-1:OUT_BITS]);
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [RANGE_W-1:0]    s_axis_tdata;   // [15:0] range_mm
  logic                  s_axis_tuser;   // [0] range_valid
  logic                  s_axis_tlast;   // scan_last
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  // [11:0] segment_number, [28:12] first_x_mm, [45:29] first_y_mm,
  // [62:46] last_x_mm, [79:63] last_y_mm, [92:80] point_count, [95:93] zero
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;   // segment_scan_end
  logic                  psel, penable, pwrite;
  logic [3:0]            paddr;
  logic [31:0]           pwdata, prdata;
  logic                  pready;

  segment_tracker tracker;
  int       burst_left;
  int       hold_request, hold_left, mode_left;
  int unsigned beat;
  rx_mode_e rx_mode;
  longint   cycle_count;

  scan_breakpoint_segmenter_top #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .RANGE_BITS  (RANGE_BITS),
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #2 clk_i = ~clk_i;

  // Watchdog on total run length.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Receiver: switches between stall patterns; a requested hold-off keeps
  // tready low for a long stretch so the block backs up into its input.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (mode_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(RX_STREAM, RX_COIN));
        mode_left = $urandom_range(20, 300);
      end else begin
        mode_left--;
      end
      beat++;
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_STREAM:   m_axis_tready <= 1'b1;
          RX_SPARSE:   m_axis_tready <= ($urandom_range(0, 3) != 0);
          RX_PERIODIC: m_axis_tready <= ((beat % 7) >= 3);
          default:     m_axis_tready <= 1'($urandom_range(0, 1));
        endcase
      end
    end
  end

  // Segment transactions are checked at the edge that accepts them.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      tracker.match_segment(m_axis_tdata, m_axis_tlast);
  end

  // Offer one sample; tvalid stays high inside a burst, may drop for a gap after it.
  task automatic offer_sample(input logic [15:0] r, input logic valid, input logic last);
    int gap;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= r;
    s_axis_tuser  <= valid;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.take_sample(r, valid, last);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
  endtask

  // Stop sending, wait for every outstanding segment, then let the block go idle.
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (tracker.awaited.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    tracker.set_reg(idx, val);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_config(input logic [31:0] start, input logic [31:0] step,
                            input logic [31:0] join_d);
    write_reg(REG_START_ANGLE, start);
    write_reg(REG_ANGLE_STEP, step);
    write_reg(REG_JOIN_DIST, join_d);
  endtask

  // Mostly smooth scans (neighbors close, occasional jumps and dropouts),
  // some pure noise scans; every scan ends with scan_last.
  task automatic run_scans(input int quota);
    int  sent, len, k, rr;
    bit  noisy;
    logic v;
    sent = 0;
    while (sent < quota) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 30);
      noisy = ($urandom_range(0, 4) == 0);
      rr = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 6000);
      for (k = 0; k < len; k++) begin
        if (noisy) begin
          rr = $urandom_range(0, 65535);
          v = 1'($urandom_range(0, 1));
        end else begin
          if ($urandom_range(0, 11) == 0) rr = $urandom_range(0, 65535);
          else rr = rr + int'($urandom_range(0, 8)) - 4;
          if (rr < 0) rr = 0;
          else if (rr > 65535) rr = 65535;
          v = ($urandom_range(0, 7) != 0);
        end
        offer_sample(rr[15:0], v, k == len - 1);
      end
      sent += len;
    end
  endtask

  // Long single scans. The joined form piles zero-range points into one
  // segment; the other closes a segment on every point.
  task automatic run_long_scan(input bit joined);
    int k;
    for (k = 0; k < 100; k++) begin
      if (joined)
        offer_sample((k < 95) ? 16'd0 : 16'd3000, 1'b1, k == 99);
      else
        offer_sample(16'($urandom_range(0, 65535)), 1'b1, k == 99);
    end
  endtask

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    s_axis_tlast = 1'b0;
    m_axis_tready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    burst_left = 0;
    hold_request = 0;
    hold_left = 0;
    mode_left = 0;
    beat = 0;
    rx_mode = RX_STREAM;
    cycle_count = 0;
    tracker = new();

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part at the reset configuration.
    offer_sample(16'd0, 1'b0, 1'b1);          // scan with no valid point: empty segment
    offer_sample(16'd1000, 1'b1, 1'b0);       // first valid point opens a segment
    offer_sample(16'd1002, 1'b1, 1'b0);       // joins
    offer_sample(16'hFFFF, 1'b0, 1'b0);       // invalid, only the index moves
    offer_sample(16'hFFFF, 1'b1, 1'b0);       // far jump breaks the run
    offer_sample(16'hFFFF, 1'b1, 1'b1);       // beams too far apart at full range: break at end
    offer_sample(16'd500, 1'b1, 1'b0);
    offer_sample(16'd30000, 1'b1, 1'b1);      // break on the final sample
    offer_sample(16'd100, 1'b1, 1'b1);        // state cleared: single-point scan
    offer_sample(16'd200, 1'b1, 1'b0);
    offer_sample(16'd201, 1'b1, 1'b0);
    offer_sample(16'd0, 1'b1, 1'b0);          // zero range breaks
    offer_sample(16'd0, 1'b1, 1'b0);
    offer_sample(16'hAAAA, 1'b0, 1'b1);       // invalid final sample closes the segment
    offer_sample(16'h5555, 1'b1, 1'b0);
    offer_sample(16'h8000, 1'b1, 1'b0);
    offer_sample(16'h7FFF, 1'b1, 1'b1);
    settle();

    // Extremes: widest angle step and widest join distance.
    set_config(32'h0000_7FFF, 32'd4095, 32'd65535);
    run_scans(150);
    settle();

    // Every point breaks; the receiver holds off so results back up.
    set_config(32'h0000_8000, 32'd0, 32'd0);
    hold_request = 600;
    run_scans(150);
    settle();

    // Nominal settings, with a full drain in the middle.
    set_config(32'd0, 32'd46, 32'd52);
    run_scans(100);
    settle();
    run_scans(100);
    settle();

    repeat (2) begin
      set_config($urandom, $urandom_range(1, 64), $urandom_range(10, 500));
      run_scans(150);
      settle();
    end

    set_config($urandom, 32'd1, 32'd0);
    run_long_scan(1'b0);
    settle();
    set_config($urandom, 32'd1, 32'd1000);
    run_long_scan(1'b1);
    settle();

    set_config(32'h0000_C000, 32'd12, 32'd52);
    run_scans(100);
    settle();

    if (tracker.faults == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
